@@ src/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, register indexes and command codes of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned UsW      = 10;
  localparam int unsigned PreW     = 8;

  // register indexes
  localparam logic [CfgAddrW-1:0] REG_CLOCKS_PER_US     = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_RESET_LOW_US      = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_PRESENCE_WAIT_US  = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_RESET_RECOVERY_US = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_SHORT_LOW_US      = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_SLOT_US           = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_READ_REST_US      = 3'd6;

  // command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic [PreW-1:0] clocks_per_us;
    logic [UsW-1:0]  reset_low_us;
    logic [UsW-1:0]  presence_wait_us;
    logic [UsW-1:0]  reset_recovery_us;
    logic [UsW-1:0]  short_low_us;
    logic [UsW-1:0]  slot_us;
    logic [UsW-1:0]  read_rest_us;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
  } result_t;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b0000000001,
    PH_RST_LOW   = 10'b0000000010,
    PH_RST_WAIT  = 10'b0000000100,
    PH_RST_REC   = 10'b0000001000,
    PH_WR_LOW    = 10'b0000010000,
    PH_WR_REL    = 10'b0000100000,
    PH_RD_LOW    = 10'b0001000000,
    PH_RD_SAMPLE = 10'b0010000000,
    PH_RD_REST   = 10'b0100000000,
    PH_DONE      = 10'b1000000000
  } phase_t;

  // a zero duration counts as one microsecond
  function automatic logic [UsW-1:0] dur_fix(input logic [UsW-1:0] d);
    dur_fix = (d == '0) ? UsW'(1) : d;
  endfunction

endpackage

@@ src/owm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Timing register file, written through a plain index/data write port.
// ----------------------------------------------------------------------------
module owm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [owm_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [owm_pkg::CfgDataW-1:0]  cfg_wdata,
  output owm_pkg::cfg_t                 cfg
);

  owm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clocks_per_us     <= 8'd16;
      cfg_r.reset_low_us      <= 10'd480;
      cfg_r.presence_wait_us  <= 10'd80;
      cfg_r.reset_recovery_us <= 10'd400;
      cfg_r.short_low_us      <= 10'd5;
      cfg_r.slot_us           <= 10'd65;
      cfg_r.read_rest_us      <= 10'd50;
    end else if (cfg_we) begin
      case (cfg_addr)
        owm_pkg::REG_CLOCKS_PER_US:     cfg_r.clocks_per_us     <= cfg_wdata[7:0];
        owm_pkg::REG_RESET_LOW_US:      cfg_r.reset_low_us      <= cfg_wdata;
        owm_pkg::REG_PRESENCE_WAIT_US:  cfg_r.presence_wait_us  <= cfg_wdata;
        owm_pkg::REG_RESET_RECOVERY_US: cfg_r.reset_recovery_us <= cfg_wdata;
        owm_pkg::REG_SHORT_LOW_US:      cfg_r.short_low_us      <= cfg_wdata;
        owm_pkg::REG_SLOT_US:           cfg_r.slot_us           <= cfg_wdata;
        owm_pkg::REG_READ_REST_US:      cfg_r.read_rest_us      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/owm_core.sv @@
// ----------------------------------------------------------------------------
// owm_core
// Bus sequencer: phase, bit counter, shift byte and microsecond timer.
// Advances by one bus clock each time step is high.
// ----------------------------------------------------------------------------
module owm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        command,
  input  logic [7:0]        data_byte,
  input  logic              line_level,
  input  owm_pkg::cfg_t     cfg,
  output owm_pkg::result_t  res
);

  localparam int unsigned UsW  = owm_pkg::UsW;
  localparam int unsigned PreW = owm_pkg::PreW;

  owm_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]      bit_index_r, bit_index_nxt;
  logic [7:0]      shift_byte_r, shift_byte_nxt;
  logic [PreW-1:0] tick_r, tick_nxt;
  logic [UsW-1:0]  us_rem_r, us_rem_nxt;
  logic            presence_r, presence_nxt;
  logic [7:0]      read_hold_r, read_hold_nxt;

  logic [PreW-1:0] cpu;
  logic [PreW-1:0] tick_inc;
  logic [UsW-1:0]  us_dec;
  logic [7:0]      shift_dn;

  // outputs reflect the state before this bus clock
  always_comb begin
    res.drive_low = (phase_r == owm_pkg::PH_RST_LOW) || (phase_r == owm_pkg::PH_WR_LOW) ||
                    (phase_r == owm_pkg::PH_RD_LOW);
    res.busy_res  = !((phase_r == owm_pkg::PH_IDLE) || (phase_r == owm_pkg::PH_DONE));
    res.done_res  = (phase_r == owm_pkg::PH_DONE);
    res.presence  = presence_r;
    res.read_byte = read_hold_r;
  end

  always_comb begin
    phase_nxt     = phase_r;
    bit_index_nxt = bit_index_r;
    shift_byte_nxt = shift_byte_r;
    tick_nxt      = tick_r;
    us_rem_nxt    = us_rem_r;
    presence_nxt  = presence_r;
    read_hold_nxt = read_hold_r;

    cpu      = (cfg.clocks_per_us == '0) ? PreW'(1) : cfg.clocks_per_us;
    tick_inc = tick_r + PreW'(1);
    us_dec   = (us_rem_r != '0) ? (us_rem_r - UsW'(1)) : us_rem_r;
    shift_dn = {1'b0, shift_byte_r[7:1]};

    case (phase_r)
      owm_pkg::PH_IDLE, owm_pkg::PH_DONE: begin
        phase_nxt = owm_pkg::PH_IDLE;
        if (command != owm_pkg::CMD_NONE) begin
          bit_index_nxt = '0;
          tick_nxt      = '0;
          case (command)
            owm_pkg::CMD_RESET: begin
              phase_nxt  = owm_pkg::PH_RST_LOW;
              us_rem_nxt = owm_pkg::dur_fix(cfg.reset_low_us);
            end
            owm_pkg::CMD_WRITE: begin
              shift_byte_nxt = data_byte;
              phase_nxt      = owm_pkg::PH_WR_LOW;
              us_rem_nxt     = owm_pkg::dur_fix(data_byte[0] ? cfg.short_low_us : cfg.slot_us);
            end
            default: begin
              shift_byte_nxt = '0;
              phase_nxt      = owm_pkg::PH_RD_LOW;
              us_rem_nxt     = owm_pkg::dur_fix(cfg.short_low_us);
            end
          endcase
        end
      end
      owm_pkg::PH_RD_SAMPLE: begin
        shift_byte_nxt = {line_level, shift_byte_r[7:1]};
        phase_nxt      = owm_pkg::PH_RD_REST;
        tick_nxt       = '0;
        us_rem_nxt     = owm_pkg::dur_fix(cfg.read_rest_us);
      end
      default: begin
        if (tick_inc >= cpu) begin
          tick_nxt   = '0;
          us_rem_nxt = us_dec;
          if (us_dec == '0) begin
            // end of the timed phase
            case (phase_r)
              owm_pkg::PH_RST_LOW: begin
                phase_nxt  = owm_pkg::PH_RST_WAIT;
                us_rem_nxt = owm_pkg::dur_fix(cfg.presence_wait_us);
              end
              owm_pkg::PH_RST_WAIT: begin
                presence_nxt = !line_level;
                phase_nxt    = owm_pkg::PH_RST_REC;
                us_rem_nxt   = owm_pkg::dur_fix(cfg.reset_recovery_us);
              end
              owm_pkg::PH_RST_REC: phase_nxt = owm_pkg::PH_DONE;
              owm_pkg::PH_WR_LOW, owm_pkg::PH_WR_REL: begin
                if ((phase_r == owm_pkg::PH_WR_LOW) && shift_byte_r[0]) begin
                  phase_nxt  = owm_pkg::PH_WR_REL;
                  us_rem_nxt = owm_pkg::dur_fix(cfg.slot_us);
                end else begin
                  shift_byte_nxt = shift_dn;
                  if (bit_index_r == 3'd7) begin
                    phase_nxt = owm_pkg::PH_DONE;
                  end else begin
                    bit_index_nxt = bit_index_r + 3'd1;
                    phase_nxt     = owm_pkg::PH_WR_LOW;
                    us_rem_nxt    = owm_pkg::dur_fix(shift_dn[0] ? cfg.short_low_us
                                                                 : cfg.slot_us);
                  end
                end
              end
              owm_pkg::PH_RD_LOW: phase_nxt = owm_pkg::PH_RD_SAMPLE;
              owm_pkg::PH_RD_REST: begin
                if (bit_index_r == 3'd7) begin
                  read_hold_nxt = shift_byte_r;
                  phase_nxt     = owm_pkg::PH_DONE;
                end else begin
                  bit_index_nxt = bit_index_r + 3'd1;
                  phase_nxt     = owm_pkg::PH_RD_LOW;
                  us_rem_nxt    = owm_pkg::dur_fix(cfg.short_low_us);
                end
              end
              default: phase_nxt = owm_pkg::PH_IDLE;
            endcase
          end
        end else begin
          tick_nxt = tick_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= owm_pkg::PH_IDLE;
      bit_index_r  <= '0;
      shift_byte_r <= '0;
      tick_r       <= '0;
      us_rem_r     <= '0;
      presence_r   <= 1'b0;
      read_hold_r  <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_byte_r <= shift_byte_nxt;
      tick_r       <= tick_nxt;
      us_rem_r     <= us_rem_nxt;
      presence_r   <= presence_nxt;
      read_hold_r  <= read_hold_nxt;
    end
  end

  // done lasts a single bus clock
  a_done_one_clock: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == owm_pkg::PH_DONE) |=> phase_r != owm_pkg::PH_DONE)
    else $error("done phase held for more than one bus clock");

  // a running timed phase never sits at zero microseconds left
  a_timer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == owm_pkg::PH_RST_LOW) || (phase_r == owm_pkg::PH_RST_WAIT) ||
    (phase_r == owm_pkg::PH_RST_REC) || (phase_r == owm_pkg::PH_WR_LOW) ||
    (phase_r == owm_pkg::PH_WR_REL) || (phase_r == owm_pkg::PH_RD_LOW) ||
    (phase_r == owm_pkg::PH_RD_REST) |-> us_rem_r != '0)
    else $error("timed phase with no time left");

  // read result only changes at the end of the last read slot
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && (phase_r == owm_pkg::PH_RD_REST)) |=> $stable(read_hold_r))
    else $error("read result changed outside the end of a read");

  // sequencer is frozen while no request is stepped in
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(bit_index_r) && $stable(tick_r))
    else $error("sequencer moved without a request");

endmodule

@@ src/one_wire_bus_master_unit.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// 1-Wire bus master: reset/presence, write byte and read byte sequences.
// ----------------------------------------------------------------------------
// Each input request is one bus clock of the master and yields exactly one
// result; one request is taken per cycle unless the output side stalls, and a
// result is offered once its request has gone through the input register and
// the sequencer step into the output register. The sequencer state advances
// only when a request moves from the input register into the output register,
// so stalls on either side stretch bus time but never drop or repeat a step.
module one_wire_bus_master_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // command[1:0], data_byte[9:2], line_level[10]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // drive_low[0], busy_res[1], done_res[2],
                                                    // presence[3], read_byte[11:4]
  input  logic                          cfg_we,
  input  logic [owm_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [owm_pkg::CfgDataW-1:0]  cfg_wdata
);

  logic             in_valid_r;
  logic [1:0]       in_cmd_r;
  logic [7:0]       in_data_r;
  logic             in_line_r;
  logic             out_valid_r;
  owm_pkg::result_t out_res_r;
  owm_pkg::result_t res;
  owm_pkg::cfg_t    cfg;
  logic             step;
  logic             in_fire;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_cmd_r  <= in_tdata[1:0];
      in_data_r <= in_tdata[9:2];
      in_line_r <= in_tdata[10];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .command    (in_cmd_r),
    .data_byte  (in_data_r),
    .line_level (in_line_r),
    .cfg        (cfg),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.read_byte, out_res_r.presence, out_res_r.done_res,
                       out_res_r.busy_res, out_res_r.drive_low};

endmodule

@@ tb/one_wire_bus_master_unit_tb.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit_tb
// Self-checking bench for the 1-Wire bus master. Every request is one bus
// clock. The bench predicts each result from its own model of the sequencer
// and compares it field by field. Stimulus starts with directed reset, write
// and read sequences, then moves to random command streams under changing
// timing settings and flow control, and ends with extreme prescaler and
// duration values.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [owm_pkg::CfgAddrW-1:0] REG_UNUSED = 3'd7;

  // predicts the bus master outputs for each accepted request
  class owm_scoreboard;
    logic [owm_pkg::CfgDataW-1:0] regs [0:6];
    owm_pkg::phase_t  phase;
    logic [2:0]       bit_pos;
    logic [7:0]       shifter;
    logic [8:0]       tick;
    logic [9:0]       us_left;
    logic             presence_seen;
    logic [7:0]       last_read;
    owm_pkg::result_t expected_outputs [$];
    int unsigned      errors;

    function new();
      regs[owm_pkg::REG_CLOCKS_PER_US]     = 10'd16;
      regs[owm_pkg::REG_RESET_LOW_US]      = 10'd480;
      regs[owm_pkg::REG_PRESENCE_WAIT_US]  = 10'd80;
      regs[owm_pkg::REG_RESET_RECOVERY_US] = 10'd400;
      regs[owm_pkg::REG_SHORT_LOW_US]      = 10'd5;
      regs[owm_pkg::REG_SLOT_US]           = 10'd65;
      regs[owm_pkg::REG_READ_REST_US]      = 10'd50;
      phase         = owm_pkg::PH_IDLE;
      bit_pos       = '0;
      shifter       = '0;
      tick          = '0;
      us_left       = '0;
      presence_seen = 1'b0;
      last_read     = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [owm_pkg::CfgAddrW-1:0] idx,
                            logic [owm_pkg::CfgDataW-1:0] val);
      if (idx == owm_pkg::REG_CLOCKS_PER_US) regs[idx] = {2'b00, val[7:0]};
      else if (idx <= owm_pkg::REG_READ_REST_US) regs[idx] = val;
    endfunction

    function bit seq_idle();
      return (phase == owm_pkg::PH_IDLE) || (phase == owm_pkg::PH_DONE);
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function void enter_phase(owm_pkg::phase_t ph, logic [9:0] dur);
      phase   = ph;
      tick    = '0;
      us_left = (dur == '0) ? 10'd1 : dur;
    endfunction

    function void start_bit();
      enter_phase(owm_pkg::PH_WR_LOW, shifter[0] ? regs[owm_pkg::REG_SHORT_LOW_US]
                                                 : regs[owm_pkg::REG_SLOT_US]);
    endfunction

    function void next_bit();
      shifter = shifter >> 1;
      if (bit_pos == 3'd7) begin
        phase = owm_pkg::PH_DONE;
      end else begin
        bit_pos = bit_pos + 3'd1;
        start_bit();
      end
    endfunction

    function void end_phase(logic line);
      case (phase)
        owm_pkg::PH_RST_LOW:
          enter_phase(owm_pkg::PH_RST_WAIT, regs[owm_pkg::REG_PRESENCE_WAIT_US]);
        owm_pkg::PH_RST_WAIT: begin
          presence_seen = !line;
          enter_phase(owm_pkg::PH_RST_REC, regs[owm_pkg::REG_RESET_RECOVERY_US]);
        end
        owm_pkg::PH_RST_REC: phase = owm_pkg::PH_DONE;
        owm_pkg::PH_WR_LOW: begin
          if (shifter[0]) enter_phase(owm_pkg::PH_WR_REL, regs[owm_pkg::REG_SLOT_US]);
          else next_bit();
        end
        owm_pkg::PH_WR_REL: next_bit();
        owm_pkg::PH_RD_LOW: phase = owm_pkg::PH_RD_SAMPLE;
        owm_pkg::PH_RD_REST: begin
          if (bit_pos == 3'd7) begin
            last_read = shifter;
            phase     = owm_pkg::PH_DONE;
          end else begin
            bit_pos = bit_pos + 3'd1;
            enter_phase(owm_pkg::PH_RD_LOW, regs[owm_pkg::REG_SHORT_LOW_US]);
          end
        end
        default: phase = owm_pkg::PH_IDLE;
      endcase
    endfunction

    function void note_request(logic [1:0] cmd, logic [7:0] data, logic line);
      owm_pkg::result_t r;
      logic [8:0]       prescale;
      r.drive_low = (phase == owm_pkg::PH_RST_LOW) || (phase == owm_pkg::PH_WR_LOW) ||
                    (phase == owm_pkg::PH_RD_LOW);
      r.busy_res  = !seq_idle();
      r.done_res  = (phase == owm_pkg::PH_DONE);
      r.presence  = presence_seen;
      r.read_byte = last_read;
      expected_outputs.push_back(r);
      if (seq_idle()) begin
        phase = owm_pkg::PH_IDLE;
        if (cmd != owm_pkg::CMD_NONE) begin
          bit_pos = '0;
          case (cmd)
            owm_pkg::CMD_RESET:
              enter_phase(owm_pkg::PH_RST_LOW, regs[owm_pkg::REG_RESET_LOW_US]);
            owm_pkg::CMD_WRITE: begin
              shifter = data;
              start_bit();
            end
            default: begin
              shifter = '0;
              enter_phase(owm_pkg::PH_RD_LOW, regs[owm_pkg::REG_SHORT_LOW_US]);
            end
          endcase
        end
      end else if (phase == owm_pkg::PH_RD_SAMPLE) begin
        shifter = {line, shifter[7:1]};
        enter_phase(owm_pkg::PH_RD_REST, regs[owm_pkg::REG_READ_REST_US]);
      end else begin
        // a zero prescaler counts as one clock per microsecond
        prescale = (regs[owm_pkg::REG_CLOCKS_PER_US][7:0] == '0)
                   ? 9'd1 : {1'b0, regs[owm_pkg::REG_CLOCKS_PER_US][7:0]};
        tick = tick + 9'd1;
        if (tick >= prescale) begin
          tick = '0;
          if (us_left != '0) us_left = us_left - 10'd1;
          if (us_left == '0) end_phase(line);
        end
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(owm_pkg::result_t got);
      owm_pkg::result_t want;
      if (expected_outputs.size() == 0) begin
        flag($sformatf("unexpected result: drive_low=%0b busy=%0b done=%0b presence=%0b byte=%02h",
                       got.drive_low, got.busy_res, got.done_res, got.presence, got.read_byte));
        return;
      end
      want = expected_outputs.pop_front();
      if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
          got.done_res !== want.done_res || got.presence !== want.presence ||
          got.read_byte !== want.read_byte) begin
        flag($sformatf({"mismatch: exp drive_low=%0b busy=%0b done=%0b presence=%0b byte=%02h",
                        " got drive_low=%0b busy=%0b done=%0b presence=%0b byte=%02h"},
                       want.drive_low, want.busy_res, want.done_res, want.presence,
                       want.read_byte, got.drive_low, got.busy_res, got.done_res,
                       got.presence, got.read_byte));
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [15:0]                  in_tdata   = '0;  // command[1:0], data_byte[9:2], line_level[10]
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [15:0]                  out_tdata;        // drive_low[0], busy_res[1], done_res[2],
                                                  // presence[3], read_byte[11:4]
  logic                         cfg_we     = 1'b0;
  logic [owm_pkg::CfgAddrW-1:0] cfg_addr   = '0;
  logic [owm_pkg::CfgDataW-1:0] cfg_wdata  = '0;

  owm_scoreboard sb;
  int unsigned   cycles         = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_reqs      = 0;
  int unsigned   hold_seen      = 0;
  int unsigned   hold_left      = 0;

  one_wire_bus_master_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic owm_pkg::result_t to_result(logic [15:0] d);
    owm_pkg::result_t r;
    r.drive_low = d[0];
    r.busy_res  = d[1];
    r.done_res  = d[2];
    r.presence  = d[3];
    r.read_byte = d[11:4];
    return r;
  endfunction

  // result side: checking, random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(to_result(out_tdata));
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic pick_line(int line_sel);
    return (line_sel == 2) ? 1'($urandom_range(0, 1)) : line_sel[0];
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] data, input logic line);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, line, data, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(cmd, data, line);
  endtask

  // idle clocks until the current command has finished on the bus
  task automatic run_out(input int line_sel);
    while (!sb.seq_idle()) send_request(owm_pkg::CMD_NONE, 8'($urandom), pick_line(line_sel));
  endtask

  task automatic run_cmd(input logic [1:0] cmd, input logic [7:0] data, input int line_sel);
    send_request(cmd, data, pick_line(line_sel));
    run_out(line_sel);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [owm_pkg::CfgAddrW-1:0] idx,
                           input logic [owm_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_timing(input logic [7:0] cpu, input logic [9:0] rst_low,
                             input logic [9:0] pres_wait, input logic [9:0] rst_rec,
                             input logic [9:0] short_low, input logic [9:0] slot,
                             input logic [9:0] rest);
    write_reg(owm_pkg::REG_CLOCKS_PER_US, {2'b00, cpu});
    write_reg(owm_pkg::REG_RESET_LOW_US, rst_low);
    write_reg(owm_pkg::REG_PRESENCE_WAIT_US, pres_wait);
    write_reg(owm_pkg::REG_RESET_RECOVERY_US, rst_rec);
    write_reg(owm_pkg::REG_SHORT_LOW_US, short_low);
    write_reg(owm_pkg::REG_SLOT_US, slot);
    write_reg(owm_pkg::REG_READ_REST_US, rest);
  endtask

  function automatic logic [9:0] rand_us();
    return ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 4));
  endfunction

  task automatic load_random_timing();
    logic [7:0] cpu;
    cpu = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
    load_timing(cpu, rand_us(), rand_us(), rand_us(), rand_us(), rand_us(), rand_us());
  endtask

  task automatic random_requests(input int n, input bit with_hold);
    logic [1:0] cmd;
    logic [7:0] data;
    int         r;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) hold_reqs++;
      r = $urandom_range(0, 99);
      if (sb.seq_idle()) begin
        cmd = (r < 10) ? owm_pkg::CMD_NONE  :
              (r < 35) ? owm_pkg::CMD_RESET :
              (r < 70) ? owm_pkg::CMD_WRITE : owm_pkg::CMD_READ;
      end else begin
        // commands while busy should be ignored
        cmd = (r < 8) ? 2'($urandom) : owm_pkg::CMD_NONE;
      end
      r = $urandom_range(0, 9);
      data = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      send_request(cmd, data, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few quiet clocks with the reset timings
    send_request(owm_pkg::CMD_NONE, 8'h00, 1'b1);
    send_request(owm_pkg::CMD_NONE, 8'hFF, 1'b0);
    drain();

    load_timing(8'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    write_reg(REG_UNUSED, 10'h3FF);
    run_cmd(owm_pkg::CMD_RESET, 8'h00, 0);
    run_cmd(owm_pkg::CMD_RESET, 8'h00, 1);
    run_cmd(owm_pkg::CMD_WRITE, 8'h00, 1);
    run_cmd(owm_pkg::CMD_WRITE, 8'hFF, 1);
    run_cmd(owm_pkg::CMD_WRITE, 8'hA5, 1);
    run_cmd(owm_pkg::CMD_READ, 8'h00, 0);
    run_cmd(owm_pkg::CMD_READ, 8'h00, 1);
    // a new read and other commands during a read
    send_request(owm_pkg::CMD_READ, 8'h00, 1'b1);
    send_request(owm_pkg::CMD_READ, 8'h3C, 1'b0);
    send_request(owm_pkg::CMD_WRITE, 8'hC3, 1'b1);
    send_request(owm_pkg::CMD_RESET, 8'h00, 1'b0);
    run_out(2);
    drain();

    // zero prescaler and zero durations
    load_timing(8'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    run_cmd(owm_pkg::CMD_RESET, 8'h00, 0);
    run_cmd(owm_pkg::CMD_WRITE, 8'h5A, 1);
    run_cmd(owm_pkg::CMD_READ, 8'h00, 2);
    drain();

    // timing change part way through a reset, prescaler lowered
    load_timing(8'd4, 10'd3, 10'd3, 10'd3, 10'd3, 10'd3, 10'd3);
    send_request(owm_pkg::CMD_RESET, 8'h00, 1'b0);
    repeat (6) send_request(owm_pkg::CMD_NONE, 8'h00, 1'b0);
    drain();
    write_reg(owm_pkg::REG_CLOCKS_PER_US, 10'd1);
    write_reg(owm_pkg::REG_PRESENCE_WAIT_US, 10'd2);
    run_out(0);
    drain();

    // random command streams under each flow-control pattern
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = (m == 1) ? 72 : (m == 3) ? 30 : 0;
      recv_stall_pct = (m == 2) ? 72 : (m == 3) ? 30 : 0;
      load_random_timing();
      random_requests(280, m == 0);
      drain();
    end

    // largest prescaler: reset low runs one full microsecond into the presence wait
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    load_timing(8'd255, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    send_request(owm_pkg::CMD_RESET, 8'h00, 1'b0);
    repeat (300) send_request(owm_pkg::CMD_NONE, 8'h00, 1'b0);
    drain();
    // prescaler dropped mid-wait, recovery then starts with the longest duration
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_timing(8'd1, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    repeat (40) send_request(owm_pkg::CMD_NONE, 8'h00, 1'b0);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
